// ===== src/hrap_pkg.sv =====
// ----------------------------------------------------------------------------
// hrap_pkg: shared types and constants for the ring-order angle-to-pixel block
// Fixed-point constants, side-band payload carried along the root chain and
// the resolution clamp used by the front and back stages.
// ----------------------------------------------------------------------------
package hrap_pkg;

  localparam int unsigned MaxNside = 8192;
  localparam int unsigned RootSteps = 31;

  // 2pi in Q28, 2/pi in Q32, 1.0 in Q30
  localparam logic signed [34:0] TwoPiQ28 = 35'sd1686629713;
  localparam logic [31:0] TwoOverPiQ32 = 32'd2734261102;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // payload that rides along with the square-root operand
  typedef struct packed {
    logic [33:0] ttq;    // azimuth scaled by 2/pi, Q2.32
    logic        pos;    // z strictly positive
    logic        polar;  // polar-cap formula selected
    logic [16:0] jp;     // equatorial edge-line index, ascending
    logic [16:0] jm;     // equatorial edge-line index, descending
  } side_t;

  // clamp the resolution register into 1..MaxNside
  function automatic logic [13:0] clamp_nside(input logic [13:0] v);
    logic [13:0] r;
    if (v == 14'd0) begin
      r = 14'd1;
    end else if (v > 14'(MaxNside)) begin
      r = 14'(MaxNside);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/hrap_root_cell.sv =====
// ----------------------------------------------------------------------------
// hrap_root_cell: one digit step of the bit-pair square root
// Each cell resolves one result bit, registers the remainder and partial
// root, and passes its side-band payload on to the next cell.
// ----------------------------------------------------------------------------
module hrap_root_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [61:0]    rem_i,
  input  logic [61:0]    root_i,
  input  hrap_pkg::side_t side_i,
  output logic           valid_o,
  output logic [61:0]    rem_o,
  output logic [61:0]    root_o,
  output hrap_pkg::side_t side_o
);
  import hrap_pkg::*;

  localparam logic [61:0] Bit = 62'd1 << (60 - 2 * STEP);

  logic [61:0] trial;
  logic [61:0] rem_d, root_d;
  logic        valid_q;
  logic [61:0] rem_q, root_q;
  side_t       side_q;

  // try the next bit pair
  always_comb begin
    trial = root_i + Bit;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  // advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ===== src/hrap_front.sv =====
// ----------------------------------------------------------------------------
// hrap_front: input conditioning, azimuth scaling and equatorial indices
// Saturates z, wraps phi, forms tt = phi*2/pi, picks the formula and builds
// the square-root operand 3(1-|z|) in Q60.
// ----------------------------------------------------------------------------
module hrap_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [13:0]         nside_i,
  input  logic                valid_i,
  input  logic signed [31:0]  cos_theta_i,
  input  logic signed [32:0]  phi_i,
  output logic                valid_o,
  output logic [61:0]         rem_o,
  output hrap_pkg::side_t     side_o
);
  import hrap_pkg::*;

  logic [2:0] valid_q;

  // stage 0
  logic signed [31:0] z_d, z0_q;
  logic signed [34:0] ph_a, ph_b;
  logic [30:0]        ph_d, ph0_q;

  // stage 1
  logic [62:0] tt_prod;
  logic [30:0] za;
  logic [32:0] za3;
  logic [30:0] wd;
  logic [31:0] w_d;
  logic [33:0] ttq1_q;
  logic signed [31:0] z1_q;
  logic        pos1_q, polar1_q;
  logic [31:0] w1_q;

  // stage 2
  logic signed [36:0] z3, a_s, b_s;
  logic [48:0] jp_prod, jm_prod;
  logic [61:0] rem2_q;
  side_t       side2_q;

  // saturate z and wrap phi once
  always_comb begin
    if (cos_theta_i > OneQ30) begin
      z_d = OneQ30;
    end else if (cos_theta_i < -OneQ30) begin
      z_d = -OneQ30;
    end else begin
      z_d = cos_theta_i;
    end
    ph_a = {{2{phi_i[32]}}, phi_i};
    if (ph_a >= TwoPiQ28) begin
      ph_a = ph_a - TwoPiQ28;
    end
    if (ph_a < 0) begin
      ph_a = ph_a + TwoPiQ28;
    end
    ph_b = ph_a;
    if (ph_b < 0) begin
      ph_b = '0;
    end
    if (ph_b >= TwoPiQ28) begin
      ph_b = TwoPiQ28 - 35'sd1;
    end
    ph_d = ph_b[30:0];
  end

  // scale azimuth, test the cap boundary, form 3(1-|z|)
  always_comb begin
    tt_prod = {32'd0, ph0_q} * {31'd0, TwoOverPiQ32};
    za      = z0_q[31] ? 31'(-z0_q) : z0_q[30:0];
    za3     = {2'b00, za} + {1'b0, za, 1'b0};
    wd      = OneQ30[30:0] - za;
    w_d     = {1'b0, wd} + {wd, 1'b0};
  end

  // equatorial edge-line indices
  always_comb begin
    z3      = 37'(z1_q) + 37'(z1_q) + 37'(z1_q);
    a_s     = 37'sd2147483648 + $signed({3'b000, ttq1_q}) - z3;
    b_s     = 37'sd2147483648 + $signed({3'b000, ttq1_q}) + z3;
    jp_prod = {35'd0, nside_i} * {14'd0, a_s[34:0]};
    jm_prod = {35'd0, nside_i} * {14'd0, b_s[34:0]};
  end

  // advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q     <= z_d;
      ph0_q    <= ph_d;
      ttq1_q   <= tt_prod[61:28];
      z1_q     <= z0_q;
      pos1_q   <= !z0_q[31] && (z0_q != 32'sd0);
      polar1_q <= za3 > 33'd2147483648;
      w1_q     <= w_d;
      rem2_q         <= {w1_q[31:0], 30'd0};
      side2_q.ttq    <= ttq1_q;
      side2_q.pos    <= pos1_q;
      side2_q.polar  <= polar1_q;
      side2_q.jp     <= jp_prod[48:32];
      side2_q.jm     <= jm_prod[48:32];
    end
  end

  assign valid_o = valid_q[2];
  assign rem_o   = rem2_q;
  assign side_o  = side2_q;

endmodule

// ===== src/hrap_back.sv =====
// ----------------------------------------------------------------------------
// hrap_back: ring and in-ring position for both formulas, final pixel select
// Polar cap uses the root s; equatorial uses the edge-line indices carried
// along the chain.
// ----------------------------------------------------------------------------
module hrap_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [13:0]     nside_i,
  input  logic            valid_i,
  input  logic [61:0]     root_i,
  input  hrap_pkg::side_t side_i,
  output logic            valid_o,
  output logic [29:0]     pixel_index_o
);
  import hrap_pkg::*;

  logic [4:0] valid_q;
  logic [15:0] nl4;

  // stage 1
  logic [43:0] ns_d;
  logic signed [17:0] ire_d;
  logic [18:0] esum;
  logic [17:0] ipe_a, ipe_d;
  logic [27:0] nsq_d;
  logic [43:0] ns1_q;
  logic signed [17:0] ire1_q;
  logic [17:0] ipe1_q;
  logic [27:0] nsq1_q;
  logic [33:0] ttq1_q;
  logic        pos1_q, polar1_q;

  // stage 2
  logic [31:0] tp, tq;
  logic [43:0] ph_d, qh_d;
  logic [63:0] pl_d, ql_d;
  logic signed [17:0] irm1;
  logic [31:0] eprod, epix;
  logic [43:0] ph2_q, qh2_q;
  logic [31:0] pl2_q, ql2_q;
  logic        tp0_2_q;
  logic [13:0] nsh2_q;
  logic [29:0] pixe2_q;
  logic [27:0] nsq2_q;
  logic [33:0] ttq2_q;
  logic        pos2_q, polar2_q;

  // stage 3
  logic [44:0] jps, jms;
  logic [14:0] jp3, jm3;
  logic [14:0] ir3_q;
  logic [29:0] pixe3_q;
  logic [27:0] nsq3_q;
  logic [33:0] ttq3_q;
  logic        pos3_q, polar3_q;

  // stage 4
  logic [48:0] ip_prod;
  logic [17:0] ip4_q;
  logic [29:0] irsq4_q;
  logic [14:0] ir4_q;
  logic [29:0] pixe4_q;
  logic [27:0] nsq4_q;
  logic        pos4_q, polar4_q;

  // stage 5
  logic [16:0] lim;
  logic [17:0] ip5;
  logic [31:0] ppix;
  logic [29:0] out_d, out_q;

  assign nl4 = {nside_i, 2'b00};

  // ring scale n*s and equatorial ring / position
  always_comb begin
    ns_d  = {30'd0, nside_i} * {14'd0, root_i[29:0]};
    nsq_d = {14'd0, nside_i} * {14'd0, nside_i};
    ire_d = $signed({4'd0, nside_i}) + 18'sd1 + $signed({1'b0, side_i.jp})
          - $signed({1'b0, side_i.jm});
    esum  = {2'b00, side_i.jp} + {2'b00, side_i.jm} + 19'(!ire_d[0]) + 19'd1
          - {5'd0, nside_i};
    ipe_a = 18'(esum >> 1) + 18'd1;
    ipe_d = (ipe_a > {2'b00, nl4}) ? ipe_a - {2'b00, nl4} : ipe_a;
  end

  // polar partial products and equatorial pixel
  always_comb begin
    tp    = ttq1_q[31:0];
    tq    = 32'(33'h1_0000_0000 - {1'b0, tp});
    ph_d  = {12'd0, tp} * {32'd0, ns1_q[43:32]};
    pl_d  = {32'd0, tp} * {32'd0, ns1_q[31:0]};
    qh_d  = {12'd0, tq} * {32'd0, ns1_q[43:32]};
    ql_d  = {32'd0, tq} * {32'd0, ns1_q[31:0]};
    irm1  = ire1_q - 18'sd1;
    eprod = $signed({16'd0, nl4}) * $signed({{14{irm1[17]}}, irm1});
    epix  = {3'd0, nsq1_q, 1'b0} - {17'd0, nside_i, 1'b0} + eprod
          + {14'd0, ipe1_q} - 32'd1;
  end

  // polar edge indices and ring
  always_comb begin
    jps = {1'b0, ph2_q} + {13'd0, pl2_q};
    jms = {1'b0, qh2_q} + {13'd0, ql2_q};
    jp3 = jps[44:30];
    jm3 = tp0_2_q ? {1'b0, nsh2_q} : jms[44:30];
  end

  // polar in-ring product
  assign ip_prod = {15'd0, ttq3_q} * {34'd0, ir3_q};

  // wrap position, pick cap, select formula
  always_comb begin
    lim = {ir4_q, 2'b00};
    ip5 = (ip4_q > {1'b0, lim}) ? ip4_q - {1'b0, lim} : ip4_q;
    if (pos4_q) begin
      ppix = {1'b0, irsq4_q, 1'b0} - {16'd0, ir4_q, 1'b0} + {14'd0, ip5};
    end else begin
      ppix = 32'({4'd0, nsq4_q} * 32'd12) - {1'b0, irsq4_q, 1'b0}
           - {16'd0, ir4_q, 1'b0} + {14'd0, ip5};
    end
    out_d = polar4_q ? 30'(ppix - 32'd1) : pixe4_q;
  end

  // advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ns1_q    <= ns_d;
      ire1_q   <= ire_d;
      ipe1_q   <= ipe_d;
      nsq1_q   <= nsq_d;
      ttq1_q   <= side_i.ttq;
      pos1_q   <= side_i.pos;
      polar1_q <= side_i.polar;

      ph2_q    <= ph_d;
      qh2_q    <= qh_d;
      pl2_q    <= pl_d[63:32];
      ql2_q    <= ql_d[63:32];
      tp0_2_q  <= (tp == 32'd0);
      nsh2_q   <= ns1_q[43:30];
      pixe2_q  <= epix[29:0];
      nsq2_q   <= nsq1_q;
      ttq2_q   <= ttq1_q;
      pos2_q   <= pos1_q;
      polar2_q <= polar1_q;

      ir3_q    <= jp3 + jm3 + 15'd1;
      pixe3_q  <= pixe2_q;
      nsq3_q   <= nsq2_q;
      ttq3_q   <= ttq2_q;
      pos3_q   <= pos2_q;
      polar3_q <= polar2_q;

      ip4_q    <= 18'(ip_prod[48:32]) + 18'd1;
      irsq4_q  <= {15'd0, ir3_q} * {15'd0, ir3_q};
      ir4_q    <= ir3_q;
      pixe4_q  <= pixe3_q;
      nsq4_q   <= nsq3_q;
      pos4_q   <= pos3_q;
      polar4_q <= polar3_q;

      out_q    <= out_d;
    end
  end

  assign valid_o       = valid_q[4];
  assign pixel_index_o = out_q;

endmodule

// ===== src/healpix_ring_angle_to_pixel.sv =====
// ----------------------------------------------------------------------------
// healpix_ring_angle_to_pixel: sky direction to ring-ordered pixel index
// Front conditioning, a chain of 31 square-root cells, back-end ring math.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------
//   input    | in_valid_i/in_stall_o  | cos_theta_i, phi_i
//   output   | out_valid_o/out_stall_i| pixel_index_o
//   config   | cfg_valid_i/cfg_ready_o| nside_i
//
// One transaction per cycle while the output is not stalled; the pipeline is 3 front
// stages, 31 root cells and 5 back stages, with the square-root chain one bit per cell.
// Reset clears all valid flags and sets nside to 1.
// A stalled output freezes the whole pipeline and raises in_stall_o.
// ----------------------------------------------------------------------------
module healpix_ring_angle_to_pixel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [13:0]        nside_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] cos_theta_i,
  input  logic signed [32:0] phi_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [29:0]        pixel_index_o
);
  import hrap_pkg::*;

  logic [13:0] nside_q;
  logic [13:0] n_c;
  logic        en;

  logic        cv  [RootSteps+1];
  logic [61:0] crem[RootSteps+1];
  logic [61:0] croot[RootSteps+1];
  side_t       cside[RootSteps+1];

  // hold the resolution register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nside_q <= 14'd1;
    end else if (cfg_valid_i) begin
      nside_q <= nside_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign n_c         = clamp_nside(nside_q);

  // advance unless the result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  hrap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .nside_i     (n_c),
    .valid_i     (in_valid_i),
    .cos_theta_i (cos_theta_i),
    .phi_i       (phi_i),
    .valid_o     (cv[0]),
    .rem_o       (crem[0]),
    .side_o      (cside[0])
  );

  assign croot[0] = '0;

  // square-root cell chain
  for (genvar g = 0; g < RootSteps; g++) begin : g_cell
    hrap_root_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[g]),
      .rem_i   (crem[g]),
      .root_i  (croot[g]),
      .side_i  (cside[g]),
      .valid_o (cv[g+1]),
      .rem_o   (crem[g+1]),
      .root_o  (croot[g+1]),
      .side_o  (cside[g+1])
    );
  end

  hrap_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .nside_i       (n_c),
    .valid_i       (cv[RootSteps]),
    .root_i        (croot[RootSteps]),
    .side_i        (cside[RootSteps]),
    .valid_o       (out_valid_o),
    .pixel_index_o (pixel_index_o)
  );

endmodule

// ===== tb/sv/healpix_ring_angle_to_pixel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// healpix_ring_angle_to_pixel_tb: ring-order angle-to-pixel testbench
// Drives directions under several resolutions. A local pixel predictor feeds
// a queue of expected pixel numbers, and each output transaction is compared
// against the oldest entry. Both sides idle at random.
// ----------------------------------------------------------------------------
class pixel_scoreboard;
  logic [29:0] pixel_q[$];
  int unsigned mismatches;
  logic [13:0] nside;

  function new();
    mismatches = 0;
    nside = 14'd1;
  endfunction

  // floor(sqrt(v)), one bit per step
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 60;
    for (int i = 0; i < 31; i++) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mulsh62(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = x * y;
    return p[125:62];
  endfunction

  function automatic logic [29:0] pixel_of(input logic signed [31:0] ct,
                                           input logic signed [32:0] ph_in);
    longint signed z, za, ph, a, b;
    logic [63:0] n, npix, ncap, nl4, pix1, ir, ip, ttq, jp, jm, tp, w, s, ns;
    logic [127:0] prod;
    n = nside;
    if (n < 1) n = 1;
    if (n > 8192) n = 8192;
    npix = 12 * n * n;
    ncap = 2 * n * (n - 1);
    nl4 = 4 * n;
    z = ct;
    if (z > 64'sd1073741824) z = 64'sd1073741824;
    if (z < -64'sd1073741824) z = -64'sd1073741824;
    za = z < 0 ? -z : z;
    ph = ph_in;
    if (ph >= 64'sd1686629713) ph = ph - 64'sd1686629713;
    if (ph < 0) ph = ph + 64'sd1686629713;
    if (ph < 0) ph = 0;
    if (ph >= 64'sd1686629713) ph = 64'sd1686629713 - 1;
    prod = 128'(ph) * 128'd2734261102;
    ttq = prod[91:28];
    if (3 * za <= 2 * 64'sd1073741824) begin
      a = 64'sd2147483648 + longint'(ttq) - 3 * z;
      b = 64'sd2147483648 + longint'(ttq) + 3 * z;
      jp = (n * a) >> 32;
      jm = (n * b) >> 32;
      ir = n + 1 + jp - jm;
      ip = ((jp + jm + (ir[0] ? 64'd0 : 64'd1) + 1 - n) >> 1) + 1;
      if (ip > nl4) ip = ip - nl4;
      pix1 = ncap + nl4 * (ir - 1) + ip;
    end else begin
      tp = ttq & 64'hFFFF_FFFF;
      w = 3 * (64'd1073741824 - za);
      s = isqrt(w << 30);
      ns = n * s;
      jp = mulsh62(tp, ns);
      jm = (tp == 0) ? (ns >> 30) : mulsh62((64'd1 << 32) - tp, ns);
      ir = jp + jm + 1;
      ip = ((ttq * ir) >> 32) + 1;
      if (ip > 4 * ir) ip = ip - 4 * ir;
      if (z > 0) pix1 = 2 * ir * (ir - 1) + ip;
      else pix1 = npix - 2 * ir * (ir + 1) + ip;
    end
    return 30'(pix1 - 1);
  endfunction

  function void note_input(input logic signed [31:0] ct, input logic signed [32:0] ph);
    pixel_q.push_back(pixel_of(ct, ph));
  endfunction

  function void check_pixel(input logic [29:0] got);
    logic [29:0] want;
    if (pixel_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pixel %0d", got);
      return;
    end
    want = pixel_q.pop_front();
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("pixel mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module healpix_ring_angle_to_pixel_tb;
  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [13:0] nside_i;
  logic in_valid_i, in_stall_o;
  logic signed [31:0] cos_theta_i;
  logic signed [32:0] phi_i;
  logic out_valid_o, out_stall_i;
  logic [29:0] pixel_index_o;
  logic quiet;
  pixel_scoreboard sb;

  healpix_ring_angle_to_pixel u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .nside_i(nside_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cos_theta_i(cos_theta_i), .phi_i(phi_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pixel_index_o(pixel_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bound the run
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // stall the output at random, except in quiet stretches
  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 7);
  end

  // check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixel(pixel_index_o);
  end

  task automatic write_nside(input logic [13:0] v);
    cfg_valid_i <= 1'b1;
    nside_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.nside = v;
  endtask

  task automatic send_direction(input logic signed [31:0] ct, input logic signed [32:0] ph);
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    cos_theta_i <= ct;
    phi_i <= ph;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(ct, ph);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_cos();
    int unsigned m;
    m = $urandom_range(9);
    if (m == 0) return $urandom();
    if (m < 4) return 32'(int'($urandom_range(1073741824)) * ($urandom_range(1) ? 1 : -1));
    if (m < 6) return 32'sd1073741824 - 32'($urandom_range(5000));
    if (m < 8) return -32'sd1073741824 + 32'($urandom_range(5000));
    return 32'sd715827882 + 32'($urandom_range(40)) - 20;
  endfunction

  function automatic logic signed [32:0] rand_phi();
    logic [32:0] r;
    if ($urandom_range(9) == 0) begin
      r = {$urandom(), 1'($urandom())};
      return r;
    end
    return 33'(longint'($urandom_range(32'd1686629712)) +
               ($urandom_range(3) == 0 ? (($urandom_range(1)) ? 64'sd1686629713 : -64'sd1686629713) : 0));
  endfunction

  logic [13:0] nside_set[7] = '{14'd1, 14'd8192, 14'd0, 14'd16383, 14'd2, 14'd37, 14'd4096};

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    nside_i = 14'd1;
    in_valid_i = 1'b0;
    cos_theta_i = '0;
    phi_i = '0;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, cap boundary, phi wrap and saturation
    write_nside(14'd8192);
    send_direction(32'sd1073741824, 33'sd0);
    send_direction(-32'sd1073741824, 33'sd0);
    send_direction(32'sh7FFFFFFF, 33'sd1686629712);
    send_direction(32'sh80000000, 33'sd1686629713);
    send_direction(32'sd715827882, 33'sd421657428);
    send_direction(32'sd715827883, 33'sd421657428);
    send_direction(-32'sd715827882, 33'sd843314856);
    send_direction(-32'sd715827883, 33'sd843314856);
    send_direction(32'sd0, -33'sd1686629713);
    send_direction(32'sd0, -33'sd1);
    send_direction(32'sd0, 33'sh0FFFFFFFF);
    send_direction(32'sd0, 33'sh100000000);
    send_direction(32'sd1, 33'sd1264972284);
    send_direction(-32'sd1, 33'sd3373259426);
    send_direction(32'sd1073741823, 33'sd1);
    drain();

    foreach (nside_set[k]) begin
      write_nside(nside_set[k]);
      for (int i = 0; i < 235; i++) begin
        quiet = (k == 2 && i < 120);
        send_direction(rand_cos(), rand_phi());
      end
      quiet = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pixel_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== healpix_ring_angle_to_pixel.f =====
src/hrap_pkg.sv
src/hrap_root_cell.sv
src/hrap_front.sv
src/hrap_back.sv
src/healpix_ring_angle_to_pixel.sv
tb/sv/healpix_ring_angle_to_pixel_tb.sv
